// ===== hdl/trial_division_factorizer_core_defines.svh =====
// Assertion macros for the trial-division factorizer.
// Included by the top level; depends on nothing else.
`ifndef TRIAL_DIVISION_FACTORIZER_CORE_DEFINES_SVH
`define TRIAL_DIVISION_FACTORIZER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TDF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tdf_pkg.sv =====
// Shared constants of the trial-division factorizer.
// Depends on nothing; used by the top level.
`default_nettype none

package tdf_pkg;

  // Fixed widths of the input value and result factor ports.
  localparam int VALUE_PORT_W = 40;
  localparam int FACTOR_W     = 40;

  // Default working width of the factorizer.
  localparam int VALUE_WIDTH_DEFAULT = 40;

  // Smallest trial divisor and smallest value that has a prime factor.
  localparam int FIRST_DIVISOR = 2;

endpackage

`default_nettype wire

// ===== hdl/trial_division_factorizer_core.sv =====
// Trial-division integer factorizer: top level with a bit-serial divider.
// Depends on tdf_pkg and trial_division_factorizer_core_defines.svh.
//
// Channel   Signals                          Direction  Transfer when
// input     start, value                     in         start && !busy
// result    strobe, factor, has_factor, last out        strobe (one cycle)
//
// Each trial divides the cofactor by the trial divisor with one shared
// restoring divider, one quotient bit per cycle, then checks the bound
// and the remainder in the S_CHECK state.
// A value below two gives its result in the cycle after the transfer.
// A 40-bit prime takes about 2^20 trials.
// Synchronous reset returns the block to idle; the receiver cannot stall.
`default_nettype none
`include "trial_division_factorizer_core_defines.svh"

module trial_division_factorizer_core #(
  parameter int VALUE_WIDTH = tdf_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [tdf_pkg::VALUE_PORT_W-1:0] value,
  output logic                               busy,
  output logic                               strobe,
  output logic [tdf_pkg::FACTOR_W-1:0]       factor,
  output logic                               has_factor,
  output logic                               last
);

  // Trial divisor never exceeds 2^ceil(W/2), so it needs one bit more.
  localparam int DW    = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int CW    = $clog2(VALUE_WIDTH);
  localparam int EXT_W = (VALUE_WIDTH > tdf_pkg::FACTOR_W) ? VALUE_WIDTH
                                                            : tdf_pkg::FACTOR_W;
  localparam int IN_W  = (VALUE_WIDTH > tdf_pkg::VALUE_PORT_W) ? VALUE_WIDTH
                                                                : tdf_pkg::VALUE_PORT_W;

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;

  logic [1:0]             state;
  logic [VALUE_WIDTH-1:0] cofactor;
  logic [DW-1:0]          divisor;
  logic [VALUE_WIDTH-1:0] quo;
  logic [DW-1:0]          rem;
  logic [CW-1:0]          cnt;

  logic [IN_W-1:0]        value_ext;
  logic [VALUE_WIDTH-1:0] value_w;
  logic                   value_small;
  logic [DW:0]            rem_shift;
  logic [DW:0]            rem_sub;
  logic                   rem_fits;
  logic                   bound_hit;
  logic [EXT_W-1:0]       cof_ext;
  logic [EXT_W-1:0]       div_ext;

  assign busy = (state != S_IDLE);

  // Input value reduced to the working width.
  assign value_ext   = IN_W'(value);
  assign value_w     = value_ext[VALUE_WIDTH-1:0];
  assign value_small = (value_w < VALUE_WIDTH'(tdf_pkg::FIRST_DIVISOR));

  // One restoring division step: shift in the next dividend bit, try subtract.
  assign rem_shift = {rem, quo[VALUE_WIDTH-1]};
  assign rem_sub   = rem_shift - {1'b0, divisor};
  assign rem_fits  = (rem_shift >= {1'b0, divisor});

  // Stop once divisor > cofactor / divisor, i.e. its square exceeds the cofactor.
  assign bound_hit = (VALUE_WIDTH'(divisor) > quo);

  // Candidate factors mapped onto the result port width.
  assign cof_ext = EXT_W'(cofactor);
  assign div_ext = EXT_W'(divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      strobe   <= 1'b0;
      cofactor <= '0;
      divisor  <= DW'(tdf_pkg::FIRST_DIVISOR);
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (value_small) begin
              // No prime factor: a single empty, final result.
              strobe     <= 1'b1;
              factor     <= '0;
              has_factor <= 1'b0;
              last       <= 1'b1;
            end else begin
              cofactor <= value_w;
              divisor  <= DW'(tdf_pkg::FIRST_DIVISOR);
              quo      <= value_w;
              rem      <= '0;
              cnt      <= CW'(VALUE_WIDTH - 1);
              state    <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // Shift one quotient bit in per cycle.
          rem <= rem_fits ? rem_sub[DW-1:0] : rem_shift[DW-1:0];
          quo <= {quo[VALUE_WIDTH-2:0], rem_fits};
          cnt <= cnt - CW'(1);
          if (cnt == '0) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (bound_hit) begin
            // Remaining cofactor is prime and ends the list.
            strobe     <= 1'b1;
            factor     <= cof_ext[tdf_pkg::FACTOR_W-1:0];
            has_factor <= 1'b1;
            last       <= 1'b1;
            cofactor   <= VALUE_WIDTH'(1);
            divisor    <= DW'(tdf_pkg::FIRST_DIVISOR);
            state      <= S_IDLE;
          end else begin
            if (rem == '0) begin
              // Divisor divides: emit it and keep it for the next trial.
              strobe     <= 1'b1;
              factor     <= div_ext[tdf_pkg::FACTOR_W-1:0];
              has_factor <= 1'b1;
              last       <= 1'b0;
              cofactor   <= quo;
              quo        <= quo;
            end else begin
              divisor <= divisor + DW'(1);
              quo     <= cofactor;
            end
            rem   <= '0;
            cnt   <= CW'(VALUE_WIDTH - 1);
            state <= S_DIV;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An empty result is always final and carries a zero factor.
  `TDF_ASSERT_NOW(a_empty_final, clk, rst, strobe && !has_factor,
    last && (factor == '0), "empty result must be final with zero factor")

  // A non-final result is only produced while a factorization is running.
  `TDF_ASSERT_NOW(a_nonfinal_busy, clk, rst, strobe && !last, busy,
    "non-final result outside a factorization")

  // After the final result the block is idle again.
  `TDF_ASSERT_NOW(a_final_idle, clk, rst, strobe && last, !busy,
    "block still busy on the final result")

  // A value with prime factors starts a factorization.
  `TDF_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy && !value_small,
    busy && (divisor == DW'(tdf_pkg::FIRST_DIVISOR)),
    "factorization did not start from the first divisor")

  // The trial divisor never drops below two while working.
  `TDF_ASSERT_NOW(a_divisor_min, clk, rst, busy,
    divisor >= DW'(tdf_pkg::FIRST_DIVISOR), "trial divisor below two")

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the trial-division factorizer core.
// Depends on tdf_pkg and trial_division_factorizer_core; reads no files.
`timescale 1ns / 1ps

module testbench;

  // Shared widths and constants taken from the package.
  localparam int VALUE_PORT_W        = tdf_pkg::VALUE_PORT_W;
  localparam int FACTOR_W            = tdf_pkg::FACTOR_W;
  localparam int VALUE_WIDTH_DEFAULT = tdf_pkg::VALUE_WIDTH_DEFAULT;
  localparam int FIRST_DIVISOR       = tdf_pkg::FIRST_DIVISOR;

  // Cycles per trial of the core, and the longest run with no transfer at all.
  localparam int TRIAL_CYCLES = VALUE_WIDTH_DEFAULT + 1;
  localparam int SILENCE_LIMIT = 400_000;

  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic                has_factor;
    logic                last;
  } factor_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [VALUE_PORT_W-1:0] value = '0;
  logic                    busy;
  logic                    strobe;
  logic [FACTOR_W-1:0]     factor;
  logic                    has_factor;
  logic                    last;

  factor_result_t expected_factors[$];
  factor_result_t want;
  int             small_primes[$];
  int             error_count = 0;
  int             values_sent = 0;
  int             factors_seen = 0;
  int             silent_cycles = 0;
  int             sender_idle_pct = 0;

  trial_division_factorizer_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .value      (value),
    .busy       (busy),
    .strobe     (strobe),
    .factor     (factor),
    .has_factor (has_factor),
    .last       (last)
  );

  always #4 clk = ~clk;

  // Expected factor list of one value, in ascending order with repeats.
  function automatic void predict_factors(input logic [VALUE_PORT_W-1:0] v);
    longint unsigned rest;
    longint unsigned divisor;
    factor_result_t  r;
    rest = 64'(v);
    if (rest < FIRST_DIVISOR) begin
      r.factor = '0;
      r.has_factor = 1'b0;
      r.last = 1'b1;
      expected_factors = {expected_factors, r};
      return;
    end
    divisor = 64'(FIRST_DIVISOR);
    r.has_factor = 1'b1;
    r.last = 1'b0;
    while (divisor <= rest / divisor) begin
      if (rest % divisor == 0) begin
        r.factor = divisor[FACTOR_W-1:0];
        expected_factors = {expected_factors, r};
        rest = rest / divisor;
      end else begin
        divisor++;
      end
    end
    // Whatever is left above one is the largest prime factor.
    if (rest > 1) begin
      r.factor = rest[FACTOR_W-1:0];
      expected_factors = {expected_factors, r};
    end
    expected_factors[expected_factors.size()-1].last = 1'b1;
  endfunction

  // Monitor: check each result strobe, then record each input transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) begin
        factors_seen++;
        if (expected_factors.size() == 0) begin
          $display("%0t ERROR: unexpected result, factor %0d has_factor %0b last %0b",
                   $time, factor, has_factor, last);
          error_count++;
        end else begin
          want = expected_factors.pop_front();
          if (factor !== want.factor) begin
            $display("%0t ERROR: factor expected %0d actual %0d",
                     $time, want.factor, factor);
            error_count++;
          end
          if (has_factor !== want.has_factor) begin
            $display("%0t ERROR: has_factor expected %0b actual %0b",
                     $time, want.has_factor, has_factor);
            error_count++;
          end
          if (last !== want.last) begin
            $display("%0t ERROR: last expected %0b actual %0b",
                     $time, want.last, last);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        predict_factors(value);
        values_sent++;
      end
    end
  end

  // Watchdog on cycles in which neither channel makes a transfer.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      silent_cycles <= 0;
    end else begin
      silent_cycles <= silent_cycles + 1;
    end
    if (silent_cycles >= SILENCE_LIMIT) begin
      $display("%0t ERROR: no transfer for %0d cycles", $time, SILENCE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one value and hold it until the core takes it.
  task automatic send_value(input logic [VALUE_PORT_W-1:0] v);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random value whose factorization stays short: a product of small primes,
  // sometimes times a cofactor of moderate size, or a small plain number.
  function automatic logic [VALUE_PORT_W-1:0] make_value();
    longint unsigned product;
    longint unsigned ceiling;
    longint unsigned p;
    int              kind;
    kind = int'($urandom_range(99));
    if (kind < 8) return VALUE_PORT_W'($urandom_range(0, 20));
    if (kind < 20) return VALUE_PORT_W'($urandom_range(0, 65535));
    ceiling = 64'd1 << $urandom_range(8, VALUE_PORT_W);
    product = 1;
    for (int i = 0; i < 60; i++) begin
      p = 64'(small_primes[$urandom_range(0, $urandom_range(0, small_primes.size() - 1))]);
      if (product * p < ceiling) product = product * p;
    end
    p = 64'($urandom_range(2, 20000));
    if ($urandom_range(1) && product * p < (64'd1 << VALUE_PORT_W)) product = product * p;
    return product[VALUE_PORT_W-1:0];
  endfunction

  // Zero and one give no factor; two and three are the smallest primes, four the smallest composite.
  task automatic test_below_two_and_tiny();
    send_value(40'd0);
    send_value(40'd1);
    send_value(40'd2);
    send_value(40'd3);
    send_value(40'd4);
  endtask

  // Full-scale values, the longest run of repeated factors and bit patterns.
  task automatic test_extreme_values();
    send_value(40'hFF_FFFF_FFFF);
    send_value(40'h80_0000_0000);
    send_value(40'd847288609443);
    send_value(40'h55_5555_5555);
    send_value(40'hAA_AAAA_AAAA);
  endtask

  // Prime inputs, a prime square, a power of two and products of distinct primes.
  task automatic test_primes_and_powers();
    send_value(40'd97);
    send_value(40'd65521);
    send_value(40'd1000003);
    send_value(40'd1018081);
    send_value(40'd1024);
    send_value(40'd30030);
    send_value(40'd6);
  endtask

  task automatic test_random_mix(input int count, input int idle_pct);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) send_value(make_value());
    sender_idle_pct = 0;
  endtask

  initial begin
    bit is_prime;
    for (int n = 2; n < 200; n++) begin
      is_prime = 1'b1;
      for (int k = 2; k * k <= n; k++) if (n % k == 0) is_prime = 1'b0;
      if (is_prime) small_primes = {small_primes, n};
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_below_two_and_tiny();
    test_extreme_values();
    test_primes_and_powers();
    test_random_mix(30, 0);
    test_random_mix(30, 50);
    test_random_mix(30, 31);
    start <= 1'b0;

    // Drain the outstanding factors, then watch for stray strobes.
    while (expected_factors.size() != 0) @(posedge clk);
    repeat (2 * TRIAL_CYCLES) @(posedge clk);

    $display("Factored %0d values into %0d checked results, sender idle at 0, 50 and 31 percent.",
             values_sent, factors_seen);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d errors found", error_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tdf_pkg.sv
hdl/trial_division_factorizer_core.sv
dv/testbench.sv
